/* hdl/les_pkg.sv */
// Shared types and constants for the looping event sequencer.
// No dependencies; every other file imports this package.
package les_pkg;

  localparam int DEF_EVENT_SLOTS = 16;
  localparam int DEF_TIME_BITS = 24;
  localparam int MAX_RESULTS = 32;
  localparam int RES_CNT_W = 6;
  localparam int TAG_W = 16;
  localparam int LOOP_W = 8;
  localparam int ITER_W = 9;
  localparam logic [ITER_W-1:0] ITER_MAX = 9'd511;
  localparam logic [ITER_W-1:0] ITER_RESET = 9'd1;
  localparam logic [63:0] PHRASE_RESET = 64'd4096;
  localparam logic [LOOP_W-1:0] LOOP_RESET = 8'd1;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PHRASE_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_TOTAL = 1'b1;
  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_INS_SHIFT,
    ST_RI_SCAN,
    ST_DRY,
    ST_RUN
  } core_state_t;

endpackage

/* hdl/les_front.sv */
// Front end: accepts input words into a short queue and classifies them.
// Depends on les_pkg.
module les_front import les_pkg::*; #(
  parameter int TIME_BITS = DEF_TIME_BITS,
  localparam int DATA_W = ((2 * TIME_BITS + TAG_W + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [DATA_W-1:0]    s_tdata,
  input  logic                 s_tuser,
  output logic                 q_valid,
  input  logic                 q_pop,
  output logic                 q_is_add,
  output logic [TIME_BITS-1:0] q_position,
  output logic [TAG_W-1:0]     q_tag,
  output logic [TIME_BITS-1:0] q_elapsed
);

  localparam int ITEM_W = 1 + 2 * TIME_BITS + TAG_W;

  logic [ITEM_W-1:0] slots [0:QUEUE_DEPTH-1];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fill;
  logic              push;
  logic [ITEM_W-1:0] head;

  assign s_tready = (fill != 2'(QUEUE_DEPTH));
  assign push = s_tvalid && s_tready;
  assign q_valid = (fill != 2'd0);
  assign head = slots[rd_ptr];
  assign q_is_add = (head[ITEM_W-1] == ACT_ADD);
  assign q_position = head[TIME_BITS-1:0];
  assign q_tag = head[TIME_BITS+TAG_W-1:TIME_BITS];
  assign q_elapsed = head[2*TIME_BITS+TAG_W-1:TIME_BITS+TAG_W];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= {s_tuser, s_tdata[ITEM_W-2:0]};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule

/* hdl/les_core.sv */
// Back end: event table, time keeping, insertion and advance sequencing.
// Depends on les_pkg.
module les_core import les_pkg::*; #(
  parameter int EVENT_SLOTS = DEF_EVENT_SLOTS,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_BITS-1:0] cfg_data,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  logic                 q_is_add,
  input  logic [TIME_BITS-1:0] q_position,
  input  logic [TAG_W-1:0]     q_tag,
  input  logic [TIME_BITS-1:0] q_elapsed,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [TAG_W-1:0]     out_tag,
  output logic [TIME_BITS-1:0] out_offset,
  output logic                 out_has_event,
  output logic                 out_last,
  output logic                 out_done
);

  localparam int IDX_W = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
  localparam int CNT_W = $clog2(EVENT_SLOTS + 1);
  localparam int CT_W = TIME_BITS + 1;

  logic [TIME_BITS-1:0] pos_mem [0:EVENT_SLOTS-1];
  logic [TAG_W-1:0]     tag_mem [0:EVENT_SLOTS-1];

  core_state_t state, state_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [CNT_W-1:0]     ridx, ridx_next;
  logic [CT_W-1:0]      ctime, ctime_next;
  logic [ITER_W-1:0]    iter, iter_next;
  logic [RES_CNT_W-1:0] n, n_next;
  logic [RES_CNT_W-1:0] n_total, n_total_next;
  logic                 fin, fin_next;
  logic [CT_W-1:0]      snap_time, snap_time_next;
  logic [CNT_W-1:0]     snap_ridx, snap_ridx_next;
  logic [ITER_W-1:0]    snap_iter, snap_iter_next;
  logic [TIME_BITS-1:0] phrase_length;
  logic [LOOP_W-1:0]    loop_total;
  logic [TIME_BITS-1:0] new_pos, elapsed;
  logic [TAG_W-1:0]     new_tag;
  logic                 latch_item;
  logic                 do_shift;
  logic                 load_out;
  logic                 load_has;

  logic [TIME_BITS-1:0] cur_pos;
  logic [TAG_W-1:0]     cur_tag;
  logic                 finished;
  logic                 cond;
  logic [CNT_W-1:0]     ridx_a;
  logic                 wrap;
  logic [CNT_W-1:0]     ridx_s;
  logic [CT_W-1:0]      ctime_s;
  logic [ITER_W-1:0]    iter_s;
  logic [CT_W:0]        time_sum;
  logic [CT_W-1:0]      time_added;
  logic [CT_W-1:0]      late;
  logic [TIME_BITS-1:0] offset;
  logic                 out_free;

  assign cur_pos = pos_mem[ridx[IDX_W-1:0]];
  assign cur_tag = tag_mem[ridx[IDX_W-1:0]];
  assign finished = iter > {1'b0, loop_total};
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cond = (n < RES_CNT_W'(MAX_RESULTS)) && (ridx < count) &&
           ({1'b0, cur_pos} <= ctime) && !finished;
    ridx_a = cond ? ridx + CNT_W'(1) : ridx;
    wrap = (ridx_a >= count) && (ctime >= {1'b0, phrase_length});
    ridx_s = wrap ? '0 : ridx_a;
    ctime_s = wrap ? ctime - {1'b0, phrase_length} : ctime;
    iter_s = (wrap && iter < ITER_MAX) ? iter + ITER_W'(1) : iter;
    time_sum = {1'b0, ctime} + (CT_W + 1)'(q_elapsed);
    time_added = time_sum[CT_W] ? '1 : time_sum[CT_W-1:0];
    late = ctime - {1'b0, cur_pos};
    offset = (late > {1'b0, elapsed}) ? '0 : elapsed - late[TIME_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      ridx <= '0;
      ctime <= '0;
      iter <= ITER_RESET;
      n <= '0;
      n_total <= '0;
      fin <= 1'b0;
      phrase_length <= PHRASE_RESET[TIME_BITS-1:0];
      loop_total <= LOOP_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ridx <= ridx_next;
      ctime <= ctime_next;
      iter <= iter_next;
      n <= n_next;
      n_total <= n_total_next;
      fin <= fin_next;
      if (cfg_wr_en && cfg_index == REG_PHRASE_LENGTH) begin
        phrase_length <= cfg_data;
      end
      if (cfg_wr_en && cfg_index == REG_LOOP_TOTAL) begin
        loop_total <= cfg_data[LOOP_W-1:0];
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    snap_time <= snap_time_next;
    snap_ridx <= snap_ridx_next;
    snap_iter <= snap_iter_next;
    if (latch_item) begin
      new_pos <= q_position;
      new_tag <= q_tag;
      elapsed <= q_elapsed;
    end
    if (load_out) begin
      out_tag <= load_has ? cur_tag : '0;
      out_offset <= load_has ? offset : '0;
      out_has_event <= load_has;
      out_last <= load_has ? (n + RES_CNT_W'(1) == n_total) : 1'b1;
      out_done <= fin;
    end
  end

  // Insertion writes the new entry at ridx and shifts every later entry up by one at once.
  always_ff @(posedge clk) begin
    if (do_shift) begin
      for (int j = 0; j < EVENT_SLOTS; j++) begin
        if (CNT_W'(j) == ridx) begin
          pos_mem[j] <= new_pos;
          tag_mem[j] <= new_tag;
        end else if (j > 0 && CNT_W'(j) > ridx) begin
          pos_mem[j] <= pos_mem[(j > 0) ? j - 1 : 0];
          tag_mem[j] <= tag_mem[(j > 0) ? j - 1 : 0];
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    ridx_next = ridx;
    ctime_next = ctime;
    iter_next = iter;
    n_next = n;
    n_total_next = n_total;
    fin_next = fin;
    snap_time_next = snap_time;
    snap_ridx_next = snap_ridx;
    snap_iter_next = snap_iter;
    q_pop = 1'b0;
    latch_item = 1'b0;
    do_shift = 1'b0;
    load_out = 1'b0;
    load_has = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          latch_item = 1'b1;
          if (q_is_add) begin
            if (count < CNT_W'(EVENT_SLOTS)) begin
              ridx_next = '0;
              state_next = ST_INS_SCAN;
            end
          end else if (count != '0 && !finished) begin
            ctime_next = time_added;
            snap_time_next = time_added;
            snap_ridx_next = ridx;
            snap_iter_next = iter;
            n_next = '0;
            state_next = ST_DRY;
          end
        end
      end
      ST_INS_SCAN: begin
        if (ridx < count && cur_pos <= new_pos) begin
          ridx_next = ridx + CNT_W'(1);
        end else begin
          state_next = ST_INS_SHIFT;
        end
      end
      ST_INS_SHIFT: begin
        do_shift = 1'b1;
        count_next = count + CNT_W'(1);
        ridx_next = '0;
        state_next = ST_RI_SCAN;
      end
      ST_RI_SCAN: begin
        if (ridx < count && {1'b0, cur_pos} < ctime) begin
          ridx_next = ridx + CNT_W'(1);
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DRY: begin
        ridx_next = ridx_s;
        ctime_next = ctime_s;
        iter_next = iter_s;
        if (cond) begin
          n_next = n + RES_CNT_W'(1);
        end else begin
          fin_next = iter_s > {1'b0, loop_total};
          n_total_next = n;
          n_next = '0;
          ridx_next = snap_ridx;
          ctime_next = snap_time;
          iter_next = snap_iter;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cond) begin
          if (out_free) begin
            load_out = 1'b1;
            load_has = 1'b1;
            ridx_next = ridx_s;
            ctime_next = ctime_s;
            iter_next = iter_s;
            n_next = n + RES_CNT_W'(1);
          end
        end else if (n_total != '0 || out_free) begin
          load_out = (n_total == '0);
          ridx_next = ridx_s;
          ctime_next = ctime_s;
          iter_next = iter_s;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/looping_event_sequencer_top.sv */
// Looping event sequencer: an add scans the table one entry per cycle to find the insertion
// point, then rescans it to place the read index. An advance first makes a dry pass that settles
// the done flag, then replays the same events to send the results out.
// Items run one at a time; a two-word input queue and an output register decouple the ports.
// Reset (rst, synchronous) empties the table, zeroes time and restores the register defaults.
// Depends on les_pkg, les_front and les_core.
module looping_event_sequencer_top import les_pkg::*; #(
  parameter int EVENT_SLOTS = DEF_EVENT_SLOTS,
  parameter int TIME_BITS = DEF_TIME_BITS,
  localparam int IN_W = ((2 * TIME_BITS + TAG_W + 7) / 8) * 8,
  localparam int OUT_W = ((TIME_BITS + TAG_W + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_BITS-1:0] cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_W-1:0]      s_tdata,  // event_position, event_tag, elapsed
  input  logic                 s_tuser,  // action
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,  // fired_tag, fire_offset
  output logic [1:0]           m_tuser,  // has_event, done_res
  output logic                 m_tlast
);

  logic                 q_valid;
  logic                 q_pop;
  logic                 q_is_add;
  logic [TIME_BITS-1:0] q_position;
  logic [TAG_W-1:0]     q_tag;
  logic [TIME_BITS-1:0] q_elapsed;
  logic [TAG_W-1:0]     out_tag;
  logic [TIME_BITS-1:0] out_offset;
  logic                 out_has_event;
  logic                 out_done;

  les_front #(.TIME_BITS(TIME_BITS)) u_front (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .q_valid(q_valid), .q_pop(q_pop), .q_is_add(q_is_add),
    .q_position(q_position), .q_tag(q_tag), .q_elapsed(q_elapsed)
  );

  les_core #(.EVENT_SLOTS(EVENT_SLOTS), .TIME_BITS(TIME_BITS)) u_core (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .q_valid(q_valid), .q_pop(q_pop), .q_is_add(q_is_add),
    .q_position(q_position), .q_tag(q_tag), .q_elapsed(q_elapsed),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_tag(out_tag),
    .out_offset(out_offset), .out_has_event(out_has_event),
    .out_last(m_tlast), .out_done(out_done)
  );

  assign m_tdata = OUT_W'({out_offset, out_tag});
  assign m_tuser = {out_done, out_has_event};

endmodule
